/* hdl/stun_message_parser_defines.svh */
// Assertion macros shared by the parser modules.
`ifndef STUN_MESSAGE_PARSER_DEFINES_SVH
`define STUN_MESSAGE_PARSER_DEFINES_SVH

// Checks that an implication holds at every clock edge outside reset.
`define STP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that a condition leads to another one in the next cycle.
`define STP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/stp_pkg.sv */
// ----------------------------------------------------------------------------
// STUN parser package
// Shared constants, types and the CRC-32 byte update for the STUN parser.
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

    localparam int MaxLen = 2048;
    localparam int HdrSize = 20;
    localparam int PosW = 12;

    localparam logic [15:0] ATT_USERNAME    = 16'h0006;
    localparam logic [15:0] ATT_INTEGRITY   = 16'h0008;
    localparam logic [15:0] ATT_ERROR       = 16'h0009;
    localparam logic [15:0] ATT_XOR_ADDR    = 16'h0020;
    localparam logic [15:0] ATT_PRIORITY    = 16'h0024;
    localparam logic [15:0] ATT_USE_CAND    = 16'h0025;
    localparam logic [15:0] ATT_FINGERPRINT = 16'h8028;
    localparam logic [15:0] ATT_CONTROLLED  = 16'h8029;
    localparam logic [15:0] ATT_CONTROLLING = 16'h802A;

    localparam int FL_USE_CAND    = 0;
    localparam int FL_INTEGRITY   = 1;
    localparam int FL_FINGERPRINT = 2;
    localparam int FL_XOR_ADDR    = 3;
    localparam int FL_NOT_IPV4    = 4;
    localparam int FL_USERNAME    = 5;

    localparam logic [31:0] COOKIE    = 32'h2112A442;
    localparam logic [31:0] FP_XOR    = 32'h5354554e;
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [15:0] METH_LOW  = 16'h000f;
    localparam logic [15:0] METH_MID  = 16'h00e0;
    localparam logic [15:0] METH_HIGH = 16'h3E00;
    localparam logic [7:0]  TYPE_MAX  = 8'h03;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_NOT_STUN    = 4'd1,
        ST_BAD_LENGTH  = 4'd2,
        ST_OVERRUN     = 4'd3,
        ST_AFTER_FP    = 4'd4,
        ST_AFTER_INT   = 4'd5,
        ST_BAD_ATTR    = 4'd6,
        ST_TRAILING    = 4'd7,
        ST_FP_MISMATCH = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        PH_HEADER   = 2'd0,
        PH_ATTR_HDR = 2'd1,
        PH_ATTR_VAL = 2'd2
    } phase_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [11:0] method;
        logic [1:0]  class_code;
        logic [31:0] priority_res;
        logic [63:0] controlling_tiebreak;
        logic [63:0] controlled_tiebreak;
        logic [14:0] error_value;
        logic [31:0] mapped_ip;
        logic [15:0] mapped_port;
        logic [5:0]  present_flags;
        logic [10:0] integrity_offset;
        logic [10:0] username_length;
    } result_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hdl/stp_stream_if.sv */
// ----------------------------------------------------------------------------
// STUN parser stream interface
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface stp_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/stp_parse_core.sv */
// ----------------------------------------------------------------------------
// STUN parse core
// Per-byte header and attribute walk; builds the result on the final byte.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stun_message_parser_defines.svh"

module stp_parse_core
    import stp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step,
    input  wire item_t   item,
    output result_t      result,
    output logic         result_valid
);

    logic [PosW-1:0] pos_reg, pos_next;
    logic [15:0] hlen_reg, hlen_next;
    logic [15:0] type_reg, type_next;
    logic [15:0] atype_reg, atype_next;
    logic [15:0] alen_reg, alen_next;
    logic [15:0] left_reg, left_next;
    logic [63:0] vshift_reg, vshift_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] crcs_reg, crcs_next;
    phase_t      phase_reg, phase_next;
    logic [3:0]  err_reg, err_next;
    logic [5:0]  flags_reg, flags_next;
    logic        hbad_reg, hbad_next;
    logic [1:0]  hcnt_reg, hcnt_next;
    logic [PosW-1:0] astart_reg, astart_next;
    logic [31:0] fp_reg, fp_next;
    logic [31:0] prio_reg, prio_next;
    logic [63:0] ctlg_reg, ctlg_next;
    logic [63:0] ctld_reg, ctld_next;
    logic [14:0] errv_reg, errv_next;
    logic [31:0] ip_reg, ip_next;
    logic [15:0] port_reg, port_next;
    logic [10:0] ioff_reg, ioff_next;
    logic [10:0] ulen_reg, ulen_next;

    logic [7:0]  b;
    logic [16:0] msg_end;
    logic [17:0] attr_end;
    logic [16:0] padded;
    logic [16:0] idx;
    logic [15:0] alen_full;
    logic [15:0] atype_full;
    logic        walk;
    logic        need_chk;
    logic [15:0] need;
    logic [63:0] vnew;
    logic [PosW-1:0] total;
    logic [3:0]  status;

    always_comb
    begin
        b = item.data_byte;
        pos_next = pos_reg; hlen_next = hlen_reg; type_next = type_reg;
        atype_next = atype_reg; alen_next = alen_reg; left_next = left_reg;
        vshift_next = vshift_reg; crcs_next = crcs_reg; phase_next = phase_reg;
        err_next = err_reg; flags_next = flags_reg; hbad_next = hbad_reg;
        hcnt_next = hcnt_reg; astart_next = astart_reg; fp_next = fp_reg;
        prio_next = prio_reg; ctlg_next = ctlg_reg; ctld_next = ctld_reg;
        errv_next = errv_reg; ip_next = ip_reg; port_next = port_reg;
        ioff_next = ioff_reg; ulen_next = ulen_reg;
        msg_end = 17'(HdrSize) + {1'b0, hlen_reg};
        alen_full = {alen_reg[15:8], b};
        atype_full = atype_reg;
        attr_end = {6'd0, astart_reg} + 18'd4 + {2'd0, alen_full};
        padded = ({1'b0, alen_reg} + 17'd3) & ~17'd3;
        idx = padded - {1'b0, left_reg};
        vnew = (vshift_reg << 8) | {56'd0, b};
        need_chk = 1'b1;
        need = 16'd0;
        walk = (pos_reg >= PosW'(HdrSize)) && (err_reg == 4'd0)
            && ({5'd0, pos_reg} < msg_end) && (pos_reg < PosW'(MaxLen));

        if (pos_reg < PosW'(HdrSize)) begin
            case (pos_reg[4:0])
                5'd0:
                begin
                    if (b >= TYPE_MAX) hbad_next = 1'b1;
                    type_next = {b, 8'd0};
                end
                5'd1: type_next = {type_reg[15:8], b};
                5'd2: hlen_next = {b, 8'd0};
                5'd3: hlen_next = {hlen_reg[15:8], b};
                5'd4: if (b != COOKIE[31:24]) hbad_next = 1'b1;
                5'd5: if (b != COOKIE[23:16]) hbad_next = 1'b1;
                5'd6: if (b != COOKIE[15:8]) hbad_next = 1'b1;
                5'd7: if (b != COOKIE[7:0]) hbad_next = 1'b1;
                default: ;
            endcase
            if (pos_reg == PosW'(HdrSize - 1)) phase_next = PH_ATTR_HDR;
        end else if (walk && phase_reg == PH_ATTR_HDR) begin
            case (hcnt_reg)
                2'd0:
                begin
                    crcs_next = crc_reg;
                    astart_next = pos_reg;
                    atype_next = {b, 8'd0};
                end
                2'd1: atype_next = {atype_reg[15:8], b};
                2'd2: alen_next = {b, 8'd0};
                default:
                begin
                    alen_next = alen_full;
                    case (atype_full)
                        ATT_PRIORITY, ATT_FINGERPRINT, ATT_ERROR: need = 16'd4;
                        ATT_CONTROLLING, ATT_CONTROLLED, ATT_XOR_ADDR: need = 16'd8;
                        ATT_USE_CAND: need = 16'd0;
                        ATT_INTEGRITY: need = 16'd20;
                        default: need_chk = 1'b0;
                    endcase
                    if (attr_end > {1'b0, msg_end}) err_next = ST_OVERRUN;
                    else if (flags_reg[FL_FINGERPRINT]) err_next = ST_AFTER_FP;
                    else if (flags_reg[FL_INTEGRITY] && atype_full != ATT_FINGERPRINT)
                        err_next = ST_AFTER_INT;
                    else if (need_chk && alen_full != need) err_next = ST_BAD_ATTR;
                    else begin
                        case (atype_full)
                            ATT_USERNAME:
                            begin
                                flags_next[FL_USERNAME] = 1'b1;
                                ulen_next = alen_full[10:0];
                            end
                            ATT_USE_CAND: flags_next[FL_USE_CAND] = 1'b1;
                            ATT_INTEGRITY:
                            begin
                                flags_next[FL_INTEGRITY] = 1'b1;
                                ioff_next = 11'(astart_reg + PosW'(4));
                            end
                            ATT_FINGERPRINT: flags_next[FL_FINGERPRINT] = 1'b1;
                            default: ;
                        endcase
                        vshift_next = 64'd0;
                        left_next = 16'(({1'b0, alen_full} + 17'd3) & ~17'd3);
                        phase_next = (alen_full == 16'd0) ? PH_ATTR_HDR : PH_ATTR_VAL;
                    end
                end
            endcase
            hcnt_next = hcnt_reg + 2'd1;
        end else if (walk) begin
            if (idx < {1'b0, alen_reg} && idx < 17'd8) vshift_next = vnew;
            else vnew = vshift_reg;
            left_next = left_reg - 16'd1;
            if (idx + 17'd1 == {1'b0, alen_reg}) begin
                case (atype_reg)
                    ATT_PRIORITY: prio_next = vnew[31:0];
                    ATT_CONTROLLING: ctlg_next = vnew;
                    ATT_CONTROLLED: ctld_next = vnew;
                    ATT_ERROR: errv_next = ({7'd0, vnew[15:8]} * 15'd100) + {7'd0, vnew[7:0]};
                    ATT_XOR_ADDR:
                    begin
                        flags_next[FL_XOR_ADDR] = 1'b1;
                        flags_next[FL_NOT_IPV4] = (vnew[63:48] != 16'd1);
                        port_next = vnew[47:32] ^ COOKIE[31:16];
                        ip_next = vnew[31:0] ^ COOKIE;
                    end
                    ATT_FINGERPRINT: fp_next = vnew[31:0];
                    default: ;
                endcase
            end
            if (left_reg == 16'd1) phase_next = PH_ATTR_HDR;
        end
        crc_next = crc_byte(crc_reg, b);
        if (pos_reg <= PosW'(MaxLen)) pos_next = pos_reg + PosW'(1);

        total = pos_next;
        if (total < PosW'(HdrSize) || hbad_next) status = ST_NOT_STUN;
        else if (total > PosW'(MaxLen) || hlen_next != 16'(total - PosW'(HdrSize))
            || hlen_next[1:0] != 2'd0) status = ST_BAD_LENGTH;
        else if (err_next != 4'd0) status = err_next;
        else if (phase_next != PH_ATTR_HDR || hcnt_next != 2'd0) status = ST_TRAILING;
        else if (flags_next[FL_FINGERPRINT] && fp_next != (~crcs_next ^ FP_XOR))
            status = ST_FP_MISMATCH;
        else status = ST_OK;

        result = '0;
        result.status = status;
        if (status == ST_OK) begin
            result.method = 12'((type_next & METH_LOW) | ((type_next & METH_MID) >> 1)
                | ((type_next & METH_HIGH) >> 2));
            result.class_code = {type_next[8], type_next[4]};
            result.priority_res = prio_next;
            result.controlling_tiebreak = ctlg_next;
            result.controlled_tiebreak = ctld_next;
            result.error_value = errv_next;
            result.mapped_ip = ip_next;
            result.mapped_port = port_next;
            result.present_flags = flags_next;
            result.integrity_offset = ioff_next;
            result.username_length = ulen_next;
        end
        result_valid = step && item.last_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= '0; hlen_reg <= '0; type_reg <= '0; atype_reg <= '0;
            alen_reg <= '0; left_reg <= '0; vshift_reg <= '0; crc_reg <= '1;
            crcs_reg <= '1; phase_reg <= PH_HEADER; err_reg <= '0; flags_reg <= '0;
            hbad_reg <= 1'b0; hcnt_reg <= '0; astart_reg <= '0; fp_reg <= '0;
            prio_reg <= '0; ctlg_reg <= '0; ctld_reg <= '0; errv_reg <= '0;
            ip_reg <= '0; port_reg <= '0; ioff_reg <= '0; ulen_reg <= '0;
        end else if (step && item.last_byte) begin
            // A finished message returns the walk to its reset state.
            pos_reg <= '0; hlen_reg <= '0; type_reg <= '0; atype_reg <= '0;
            alen_reg <= '0; left_reg <= '0; vshift_reg <= '0; crc_reg <= '1;
            crcs_reg <= '1; phase_reg <= PH_HEADER; err_reg <= '0; flags_reg <= '0;
            hbad_reg <= 1'b0; hcnt_reg <= '0; astart_reg <= '0; fp_reg <= '0;
            prio_reg <= '0; ctlg_reg <= '0; ctld_reg <= '0; errv_reg <= '0;
            ip_reg <= '0; port_reg <= '0; ioff_reg <= '0; ulen_reg <= '0;
        end else if (step) begin
            pos_reg <= pos_next; hlen_reg <= hlen_next; type_reg <= type_next;
            atype_reg <= atype_next; alen_reg <= alen_next; left_reg <= left_next;
            vshift_reg <= vshift_next; crc_reg <= crc_next; crcs_reg <= crcs_next;
            phase_reg <= phase_next; err_reg <= err_next; flags_reg <= flags_next;
            hbad_reg <= hbad_next; hcnt_reg <= hcnt_next; astart_reg <= astart_next;
            fp_reg <= fp_next; prio_reg <= prio_next; ctlg_reg <= ctlg_next;
            ctld_reg <= ctld_next; errv_reg <= errv_next; ip_reg <= ip_next;
            port_reg <= port_next; ioff_reg <= ioff_next; ulen_reg <= ulen_next;
        end
    end

    `STP_ASSERT_NEXT(a_last_resets, clk, rst_n, step && item.last_byte, pos_reg == '0)
    `STP_ASSERT_IMPL(a_hcnt_only_attr, clk, rst_n, hcnt_reg != 2'd0, phase_reg == PH_ATTR_HDR)
    `STP_ASSERT_IMPL(a_pos_bound, clk, rst_n, 1'b1, pos_reg <= PosW'(MaxLen + 1))

endmodule

`default_nettype wire

/* hdl/stun_message_parser.sv */
// ----------------------------------------------------------------------------
// STUN message parser
// Checks and decodes one STUN message streamed in one byte per transaction.
// ----------------------------------------------------------------------------
// Usage: the message arrives on the in_ch channel, one byte per transaction,
// with last_byte set on the final byte. Non-final bytes are always taken, so
// a message streams at one byte per clock, no gaps required, unless the final
// byte is held off as told below. When the final byte is accepted, the parse
// core forms the result from its state plus that byte, and the result appears
// on out_ch in the next cycle. Other bytes give no result.
// The result lives in an output register. While the receiver stalls with a
// result waiting, in_ch stays ready until another final byte would need the
// register; only then is in_ch held off. Bytes that are not final never wait.
// A nonzero status zeroes all other result fields.
// Reset clears the parse state to the start of a message and empties the
// output register; after each final byte the parser also returns to that
// start state on its own.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stun_message_parser_defines.svh"

module stun_message_parser
    import stp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    stp_stream_if.sink   in_ch,
    stp_stream_if.source out_ch
);

    logic    step;
    logic    res_valid;
    result_t res;
    logic    out_valid_reg;
    result_t out_data_reg;

    // A final byte needs the output register free, or being emptied now.
    assign in_ch.ready = !(in_ch.data.last_byte && out_valid_reg && !out_ch.ready);
    assign step = in_ch.valid && in_ch.ready;

    stp_parse_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .item         (in_ch.data),
        .result       (res),
        .result_valid (res_valid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (out_ch.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid) begin
            out_data_reg <= res;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_data_reg;

    `STP_ASSERT_IMPL(a_no_overwrite, clk, rst_n, out_valid_reg && !out_ch.ready, !res_valid)
    `STP_ASSERT_NEXT(a_result_shown, clk, rst_n, res_valid, out_valid_reg)
    `STP_ASSERT_IMPL(a_status_zero, clk, rst_n, out_valid_reg && out_data_reg.status != ST_OK,
        out_data_reg.present_flags == 6'd0)

endmodule

`default_nettype wire
